// ----- sv/y86ifd_pkg.sv -----
// Shared types and constants for the Y86-64 instruction fetch and decode block.
// Holds the opcode codes, the register-none code and the decoded result record.
// No dependencies.
package y86ifd_pkg;

	// Instruction classes taken from the high nibble of the first byte.
	typedef enum logic [3:0] {
		OP_HALT   = 4'd0,
		OP_NOP    = 4'd1,
		OP_CMOV   = 4'd2,
		OP_IRMOV  = 4'd3,
		OP_RMMOV  = 4'd4,
		OP_MRMOV  = 4'd5,
		OP_ALU    = 4'd6,
		OP_JUMP   = 4'd7,
		OP_CALL   = 4'd8,
		OP_RET    = 4'd9,
		OP_PUSH   = 4'd10,
		OP_POP    = 4'd11,
		OP_IOTRAP = 4'd12
	} opcode_t;

	localparam logic [3:0] NOREG = 4'hF;

	// Highest legal function code for each class that has variants.
	localparam logic [3:0] FN_MAX_CMOV   = 4'd6;
	localparam logic [3:0] FN_MAX_ALU    = 4'd3;
	localparam logic [3:0] FN_MAX_JUMP   = 4'd6;
	localparam logic [3:0] FN_MAX_IOTRAP = 4'd5;

	// Instruction lengths in bytes.
	localparam logic [3:0] LEN_SHORT = 4'd1;
	localparam logic [3:0] LEN_REG   = 4'd2;
	localparam logic [3:0] LEN_DEST  = 4'd9;
	localparam logic [3:0] LEN_FULL  = 4'd10;

	typedef struct packed {
		logic        addr_error;
		logic        is_valid;
		logic [16:0] next_pc;
		logic [63:0] const_value;
		logic [3:0]  reg_b;
		logic [3:0]  reg_a;
		logic [3:0]  func_code;
		logic [3:0]  opcode;
	} dec_t;

endpackage

// ----- sv/y86ifd_decode.sv -----
// Combinational decoder for one Y86-64 instruction window.
// Depends on y86ifd_pkg for opcode codes and the dec_t result record.
module y86ifd_decode #(
	parameter int MEM_BYTES = 4096
) (
	input  logic [15:0]       pc,
	input  logic [63:0]       bytes_lo,
	input  logic [15:0]       bytes_hi,
	output y86ifd_pkg::dec_t  dec
);
	import y86ifd_pkg::*;

	localparam logic [16:0] MemLimit = 17'(MEM_BYTES);

	logic [3:0]  op;
	logic [3:0]  fn;
	logic [3:0]  ra;
	logic [3:0]  rb;
	logic [3:0]  len;
	logic        fn_ok;
	logic        regs_used;
	logic        const_at1;
	logic        const_at2;
	logic        reg_ok;
	logic [16:0] npc;
	logic        pc_ok;
	logic        late_err;

	assign op = bytes_lo[7:4];
	assign fn = bytes_lo[3:0];
	assign ra = bytes_lo[15:12];
	assign rb = bytes_lo[11:8];

	always_comb begin
		len       = LEN_SHORT;
		fn_ok     = 1'b0;
		regs_used = 1'b0;
		const_at1 = 1'b0;
		const_at2 = 1'b0;
		reg_ok    = 1'b1;
		case (opcode_t'(op))
			OP_HALT, OP_NOP, OP_RET: begin
				fn_ok = (fn == 4'd0);
			end
			OP_CMOV, OP_ALU: begin
				len       = LEN_REG;
				fn_ok     = (opcode_t'(op) == OP_CMOV) ? (fn <= FN_MAX_CMOV)
					: (fn <= FN_MAX_ALU);
				regs_used = 1'b1;
				reg_ok    = (ra != NOREG) && (rb != NOREG);
			end
			OP_IRMOV, OP_RMMOV, OP_MRMOV: begin
				len       = LEN_FULL;
				fn_ok     = (fn == 4'd0);
				regs_used = 1'b1;
				const_at2 = 1'b1;
				reg_ok    = (opcode_t'(op) == OP_IRMOV) ? ((ra == NOREG) && (rb != NOREG))
					: (ra != NOREG);
			end
			OP_JUMP, OP_CALL: begin
				len       = LEN_DEST;
				fn_ok     = (opcode_t'(op) == OP_JUMP) ? (fn <= FN_MAX_JUMP) : (fn == 4'd0);
				const_at1 = 1'b1;
			end
			OP_PUSH, OP_POP: begin
				len       = LEN_REG;
				fn_ok     = (fn == 4'd0);
				regs_used = 1'b1;
				reg_ok    = (ra != NOREG) && (rb == NOREG);
			end
			OP_IOTRAP: begin
				fn_ok = (fn <= FN_MAX_IOTRAP);
			end
			default: begin
				fn_ok = 1'b0;
			end
		endcase
	end

	assign pc_ok    = ({1'b0, pc} < MemLimit);
	assign npc      = {1'b0, pc} + 17'(len);
	assign late_err = (npc >= MemLimit);

	always_comb begin
		dec = '0;
		if (!pc_ok) begin
			dec.addr_error = 1'b1;
		end else begin
			dec.opcode    = op;
			dec.func_code = fn;
			dec.next_pc   = npc;
			if (fn_ok && regs_used) begin
				dec.reg_a = ra;
				dec.reg_b = rb;
			end
			if (fn_ok && const_at2) begin
				dec.const_value = {bytes_hi, bytes_lo[63:16]};
			end else if (fn_ok && const_at1) begin
				dec.const_value = {bytes_hi[7:0], bytes_lo[63:8]};
			end
			dec.is_valid   = fn_ok && reg_ok && !late_err;
			dec.addr_error = late_err;
		end
	end

endmodule

// ----- sv/y86_instruction_fetch_decode_top.sv -----
// Top level of the Y86-64 instruction fetch and decode block: input register,
// decoder and result register with stream handshakes.
// Depends on y86ifd_pkg and y86ifd_decode.
//
// Throughput: one transaction per cycle while m_tready is high. The window is latched in
// an input register, decoded by one pass of combinational logic and latched in the
// result register, which drives m_tvalid; a low m_tready holds it there and stalls the
// input register once that is full as well.
// Reset (arst_n low, asynchronous) empties both stages; no result is pending after it.
module y86_instruction_fetch_decode_top #(
	parameter int MEM_BYTES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, from bit 0 up: pc[15:0], bytes_lo[63:0], bytes_hi[15:0]
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, from bit 0 up: opcode[3:0], func_code[3:0], reg_a[3:0], reg_b[3:0],
	// const_value[63:0], next_pc[16:0], is_valid, addr_error, five zero bits
	output logic [103:0] m_tdata
);
	import y86ifd_pkg::*;

	// Input stage holds the raw instruction window.
	logic        valid_s1;
	logic [15:0] pc_s1;
	logic [63:0] lo_s1;
	logic [15:0] hi_s1;

	// Result stage holds the decoded record until the consumer takes it.
	logic        valid_s2;
	dec_t        dec_s2;

	dec_t        dec_c;
	logic        adv_s2;
	logic        adv_s1;

	// The result register can load when it is empty or is being drained this cycle.
	assign adv_s2   = !valid_s2 || m_tready;
	// The input register can load when it is empty or its contents move on.
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			pc_s1 <= s_tdata[15:0];
			lo_s1 <= s_tdata[79:16];
			hi_s1 <= s_tdata[95:80];
		end
	end

	y86ifd_decode #(
		.MEM_BYTES(MEM_BYTES)
	) u_decode (
		.pc      (pc_s1),
		.bytes_lo(lo_s1),
		.bytes_hi(hi_s1),
		.dec     (dec_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, dec_s2};

	// A legal instruction never carries an address error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.is_valid) |-> !dec_s2.addr_error)
		else $error("valid instruction flagged with address error");

	// A legal instruction ends inside memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.is_valid) |-> (dec_s2.next_pc < 17'(MEM_BYTES)))
		else $error("valid instruction with next pc beyond memory");

	// An accepted window is held in the input stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted transaction lost from input stage");

	// The input stage is never overwritten while both stages are full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted while pipeline stalled");

	// An early address error reports nothing but the error flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dec_s2.addr_error && (dec_s2.next_pc == 17'd0))
		|-> (dec_s2.opcode == 4'd0 && dec_s2.const_value == 64'd0))
		else $error("fields not cleared on early address error");

endmodule

// ----- verif/y86_instruction_fetch_decode_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for y86_instruction_fetch_decode_top.
// Depends on y86ifd_pkg and the block's RTL; predicts every decode on its own.
module y86_instruction_fetch_decode_top_tb;
	import y86ifd_pkg::*;

	localparam int MEM_BYTES   = 4096;
	localparam int HOLD_CYCLES = 150;        // Long receiver hold-off used by the pressure test.
	localparam int DRAIN_WAIT  = 8;          // Extra cycles after the last result, above the latency.
	localparam int TIMEOUT_NS  = 3_000_000;  // Far above the slowest legal run.

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [95:0]  s_tdata = '0;   // pc[15:0], bytes_lo[63:0], bytes_hi[15:0] from bit 0 up
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;        // opcode, func_code, reg_a, reg_b, const_value, next_pc,
	                              // is_valid, addr_error, zero padding from bit 0 up

	// Decodes the block still owes us, oldest first.
	dec_t        pending_decodes[$];
	int          mismatches = 0;
	int          decodes_checked = 0;
	int          windows_sent = 0;
	int          input_stall_cycles = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	int          hold_requests = 0;

	y86_instruction_fetch_decode_top #(
		.MEM_BYTES(MEM_BYTES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// Independent decode of one instruction window. An out-of-range pc short-circuits
	// everything; otherwise the opcode picks the length, the legal function codes and
	// which of the register byte and the constant are reported.
	function automatic dec_t predict_decode(input logic [15:0] pc, input logic [63:0] win_lo,
			input logic [15:0] win_hi);
		dec_t       d;
		logic [3:0] len;
		logic [7:0] reg_spec;
		d = '0;
		if (pc >= MEM_BYTES) begin
			d.addr_error = 1'b1;
			return d;
		end
		d.opcode    = win_lo[7:4];
		d.func_code = win_lo[3:0];
		reg_spec    = win_lo[15:8];
		len         = LEN_SHORT;
		case (d.opcode)
			OP_HALT, OP_NOP, OP_RET: begin
				d.is_valid = (d.func_code == '0);
			end
			OP_CMOV, OP_ALU: begin
				len = LEN_REG;
				if (d.func_code <= ((d.opcode == OP_CMOV) ? FN_MAX_CMOV : FN_MAX_ALU)) begin
					d.reg_a    = reg_spec[7:4];
					d.reg_b    = reg_spec[3:0];
					d.is_valid = (d.reg_a != NOREG) && (d.reg_b != NOREG);
				end
			end
			OP_IRMOV, OP_RMMOV, OP_MRMOV: begin
				len = LEN_FULL;
				if (d.func_code == '0) begin
					d.reg_a       = reg_spec[7:4];
					d.reg_b       = reg_spec[3:0];
					d.const_value = {win_hi, win_lo[63:16]};
					if (d.opcode == OP_IRMOV)
						d.is_valid = (d.reg_a == NOREG) && (d.reg_b != NOREG);
					else
						d.is_valid = (d.reg_a != NOREG);
				end
			end
			OP_JUMP, OP_CALL: begin
				len = LEN_DEST;
				if (d.func_code <= ((d.opcode == OP_JUMP) ? FN_MAX_JUMP : 4'd0)) begin
					d.const_value = {win_hi[7:0], win_lo[63:8]};
					d.is_valid    = 1'b1;
				end
			end
			OP_PUSH, OP_POP: begin
				len = LEN_REG;
				if (d.func_code == '0) begin
					d.reg_a    = reg_spec[7:4];
					d.reg_b    = reg_spec[3:0];
					d.is_valid = (d.reg_a != NOREG) && (d.reg_b == NOREG);
				end
			end
			OP_IOTRAP: begin
				d.is_valid = (d.func_code <= FN_MAX_IOTRAP);
			end
			default: begin
				d.is_valid = 1'b0;   // The three unassigned opcodes never decode.
			end
		endcase
		d.next_pc = {1'b0, pc} + 17'(len);
		if (d.next_pc >= MEM_BYTES) begin
			d.addr_error = 1'b1;
			d.is_valid   = 1'b0;
		end
		return d;
	endfunction

	// Offers one window, with random idle cycles ahead of it, and records the
	// expected decode at the edge where the transaction is accepted.
	task automatic send_window(input logic [15:0] pc, input logic [63:0] win_lo,
			input logic [15:0] win_hi);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {win_hi, win_lo, pc};
		@(posedge clk);
		while (!s_tready) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		pending_decodes.push_back(predict_decode(pc, win_lo, win_hi));
		windows_sent++;
	endtask

	// Builds an instruction from its nibbles; the tail fills the remaining eight bytes.
	task automatic send_insn(input logic [15:0] pc, input logic [3:0] op, input logic [3:0] fn,
			input logic [3:0] ra, input logic [3:0] rb, input logic [63:0] tail);
		send_window(pc, {tail[47:0], ra, rb, op, fn}, tail[63:48]);
	endtask

	// Mostly well-formed instructions with random content, placed mostly well inside
	// memory, plus some near the top of memory, some beyond it and some raw noise.
	task automatic make_random_window(output logic [15:0] pc, output logic [63:0] win_lo,
			output logic [15:0] win_hi);
		logic [3:0]  op;
		logic [3:0]  fn;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [3:0]  fn_max;
		int unsigned pick;
		win_lo = {$urandom, $urandom};
		win_hi = 16'($urandom);
		pick   = $urandom_range(99);
		if (pick < 10) begin
			pc = 16'($urandom);
			return;
		end
		if ($urandom_range(19) == 0)
			op = 4'(OP_IOTRAP + 1 + $urandom_range(2));
		else
			op = 4'($urandom_range(OP_IOTRAP));
		case (op)
			OP_CMOV:   fn_max = FN_MAX_CMOV;
			OP_ALU:    fn_max = FN_MAX_ALU;
			OP_JUMP:   fn_max = FN_MAX_JUMP;
			OP_IOTRAP: fn_max = FN_MAX_IOTRAP;
			default:   fn_max = '0;
		endcase
		fn = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(fn_max));
		ra = ($urandom_range(7) == 0) ? NOREG : 4'($urandom_range(NOREG - 1));
		rb = ($urandom_range(7) == 0) ? NOREG : 4'($urandom_range(NOREG - 1));
		// Steer the classes with a fixed "no register" slot toward the legal form.
		if (op == OP_IRMOV && $urandom_range(4) != 0)
			ra = NOREG;
		if ((op == OP_PUSH || op == OP_POP) && $urandom_range(4) != 0)
			rb = NOREG;
		win_lo[15:0] = {ra, rb, op, fn};
		if (pick < 85)
			pc = 16'($urandom_range(MEM_BYTES - 11));
		else if (pick < 95)
			pc = 16'($urandom_range(MEM_BYTES - 1, MEM_BYTES - 12));
		else
			pc = 16'($urandom_range(16'hFFFF, MEM_BYTES));
	endtask

	task automatic send_random_windows(input int count);
		logic [15:0] pc;
		logic [63:0] win_lo;
		logic [15:0] win_hi;
		repeat (count) begin
			make_random_window(pc, win_lo, win_hi);
			send_window(pc, win_lo, win_hi);
		end
	endtask

	task automatic compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, field, want, got);
		end
	endtask

	// Compares one result transaction against the oldest pending decode.
	task automatic check_result(input logic [103:0] word);
		dec_t want;
		dec_t got;
		got = dec_t'(word[98:0]);
		if (pending_decodes.size() == 0) begin
			mismatches++;
			$display("%0t ns: result 0x%0h arrived with no decode pending", $time, word);
			return;
		end
		want = pending_decodes.pop_front();
		decodes_checked++;
		compare_field("opcode", want.opcode, got.opcode);
		compare_field("func_code", want.func_code, got.func_code);
		compare_field("reg_a", want.reg_a, got.reg_a);
		compare_field("reg_b", want.reg_b, got.reg_b);
		compare_field("const_value", want.const_value, got.const_value);
		compare_field("next_pc", want.next_pc, got.next_pc);
		compare_field("is_valid", want.is_valid, got.is_valid);
		compare_field("addr_error", want.addr_error, got.addr_error);
		compare_field("padding", '0, word[103:99]);
	endtask

	// Result side: checks every accepted transaction and drives m_tready. A new hold
	// request makes it refuse results for as long as HOLD_CYCLES sets.
	always @(posedge clk) begin : result_sink
		static int hold_left = 0;
		static int hold_seen = 0;
		if (m_tvalid && m_tready)
			check_result(m_tdata);
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Every class at the edge of its legal function codes and register rules, the
	// three unassigned opcodes, all-zero and all-one bytes, and pc values that put the
	// instruction or its successor at and just inside the end of memory.
	task automatic test_directed();
		send_insn(16'd0, OP_HALT, '0, '0, '0, '0);
		send_insn(16'd1, OP_NOP, '0, NOREG, NOREG, '1);
		send_insn(16'd2, OP_RET, 4'd1, 4'd1, 4'd2, '1);
		send_insn(16'd16, OP_CMOV, FN_MAX_CMOV, 4'd0, 4'd14, 64'h0123_4567_89AB_CDEF);
		send_insn(16'd18, OP_CMOV, FN_MAX_CMOV + 4'd1, 4'd3, 4'd4, '1);
		send_insn(16'd32, OP_ALU, FN_MAX_ALU, 4'd1, NOREG, '0);
		send_insn(16'd64, OP_IRMOV, '0, NOREG, 4'd3, '1);
		send_insn(16'd74, OP_IRMOV, '0, 4'd2, 4'd3, 64'h8000_0000_0000_0001);
		send_insn(16'd84, OP_RMMOV, '0, 4'd7, NOREG, 64'hFEDC_BA98_7654_3210);
		send_insn(16'd94, OP_RMMOV, '0, NOREG, 4'd7, 64'h5A5A_A5A5_5A5A_A5A5);
		send_insn(16'd104, OP_MRMOV, 4'd1, 4'd1, 4'd2, '1);
		send_insn(16'd112, OP_JUMP, FN_MAX_JUMP, NOREG, NOREG, '1);
		send_insn(16'd121, OP_JUMP, FN_MAX_JUMP + 4'd1, 4'd1, 4'd2, '1);
		send_insn(16'd130, OP_CALL, '0, 4'd9, 4'd8, 64'h00AA_1234_5678_9ABC);
		send_insn(16'd139, OP_CALL, 4'd1, 4'd9, 4'd8, '1);
		send_insn(16'd144, OP_PUSH, '0, 4'd5, NOREG, '1);
		send_insn(16'd146, OP_POP, '0, 4'd5, 4'd4, '1);
		send_insn(16'd148, OP_IOTRAP, FN_MAX_IOTRAP, '1, '1, '1);
		send_insn(16'd149, OP_IOTRAP, FN_MAX_IOTRAP + 4'd1, '0, '0, '0);
		for (int i = 1; i <= 3; i++)
			send_insn(16'(176 + i), 4'(OP_IOTRAP + i), '0, 4'd1, 4'd2, '1);
		// Top of memory: a one-byte instruction in the last byte, full-length
		// instructions ending exactly at and one byte before the end.
		send_insn(16'(MEM_BYTES - 1), OP_HALT, '0, '0, '0, '0);
		send_insn(16'(MEM_BYTES - 10), OP_IRMOV, '0, NOREG, 4'd1, '1);
		send_insn(16'(MEM_BYTES - 11), OP_IRMOV, '0, NOREG, 4'd1, '1);
		send_insn(16'(MEM_BYTES - 9), OP_JUMP, '0, '0, '0, '1);
		// A pc beyond memory reports nothing but the address error.
		send_insn(16'(MEM_BYTES), OP_NOP, '0, '0, '0, '0);
		send_insn(16'hFFFF, '1, '1, '1, '1, '1);
	endtask

	task automatic test_random(input int count);
		send_random_windows(count);
	endtask

	// The receiver stops for a long stretch while the sender keeps offering without
	// gaps, so both pipeline stages fill and s_tready has to drop.
	task automatic test_backpressure();
		int unsigned saved_idle;
		saved_idle      = sender_idle_pct;
		sender_idle_pct = 0;
		hold_requests++;
		send_random_windows(40);
		sender_idle_pct = saved_idle;
	endtask

	// The sender goes quiet until the block has delivered every pending decode, then
	// restarts from an empty pipeline.
	task automatic test_drain_pause();
		send_random_windows(20);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_decodes.size() != 0)
			@(posedge clk);
		send_random_windows(20);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles more rarely than the receiver.
		sender_idle_pct   = 34;
		receiver_idle_pct = 60;
		test_directed();
		test_random(350);

		// Receiver idles more rarely than the sender.
		sender_idle_pct   = 60;
		receiver_idle_pct = 34;
		test_backpressure();
		test_random(340);

		// Full rate on both sides.
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		test_drain_pause();
		test_random(320);

		s_tvalid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d decodes of %0d instruction windows; input held off on %0d cycles.",
			decodes_checked, windows_sent, input_stall_cycles);
		$display("Covered every opcode, end-of-memory cases, three idle mixes, a long hold-off.");
		if (mismatches == 0) begin
			$display("y86_instruction_fetch_decode_top_tb passed");
		end else begin
			$display("y86_instruction_fetch_decode_top_tb failed");
		end
		$finish;
	end

	// Hard stop in case the handshakes hang.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timeout with %0d decodes still pending.", pending_decodes.size());
		$display("y86_instruction_fetch_decode_top_tb failed");
		$finish;
	end

endmodule
